@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// all macros sample on clk_i and stay quiet while rst_ni is low

`define SMUP_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

`define SMUP_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define SMUP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/smup_pkg.sv @@
`default_nettype none

package smup_pkg;

  localparam int unsigned PACKET_BYTES = 5;

  typedef enum logic [1:0] {
    KIND_MOUSE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_DATA = 3'd0,
    REG_IER  = 3'd1,
    REG_IIR  = 3'd2,
    REG_LCR  = 3'd3,
    REG_MCR  = 3'd4,
    REG_LSR  = 3'd5,
    REG_MSR  = 3'd6,
    REG_SCR  = 3'd7
  } reg_off_e;

  localparam logic [7:0] LSR_IDLE     = 8'h60;
  localparam logic [7:0] LSR_AFTER_RD = 8'h01;
  localparam logic [7:0] LCR_RESET    = 8'h03;
  localparam logic [7:0] MCR_VALUE    = 8'h83;
  localparam logic [7:0] MSR_VALUE    = 8'h01;
  localparam logic [7:0] DLL_VALUE    = 8'h60;
  localparam logic [7:0] ECHO_TRIGGER = 8'h73;
  localparam logic [7:0] ECHO_BYTE    = 8'h8f;
  localparam logic [7:0] PKT_SYNC     = 8'h80;

  localparam logic signed [7:0] HELD_MAX = 8'sd127;
  localparam logic signed [7:0] HELD_MIN = -8'sd126;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         buttons;
    logic signed [11:0] delta_x;
    logic signed [11:0] delta_y;
    logic [2:0]         port_offset;
    logic [7:0]         write_data;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_request;
    logic       data_pending;
    logic       motion_held;
  } result_t;

  typedef struct packed {
    logic                              pop;
    logic                              push_one;
    logic [7:0]                        one_byte;
    logic                              push_pkt;
    logic [PACKET_BYTES-1:0][7:0]      pkt;
  } fifo_ctrl_t;

  typedef struct packed {
    logic       empty;
    logic       single;
    logic       pkt_room;
    logic [7:0] head;
  } fifo_stat_t;

  function automatic logic signed [7:0] clamp_motion(input logic signed [12:0] v);
    if (v > 13'(HELD_MAX)) return HELD_MAX;
    if (v < 13'(HELD_MIN)) return HELD_MIN;
    return v[7:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/smup_if.sv @@
`default_nettype none

interface smup_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [2:0]        buttons;
  logic signed [11:0] delta_x;
  logic signed [11:0] delta_y;
  logic [2:0]        port_offset;
  logic [7:0]        write_data;

  modport source (output valid, kind, buttons, delta_x, delta_y, port_offset, write_data,
                  input ready);
  modport sink (input valid, kind, buttons, delta_x, delta_y, port_offset, write_data,
                output ready);
endinterface

interface smup_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_request;
  logic       data_pending;
  logic       motion_held;

  modport source (output valid, read_data, irq_request, data_pending, motion_held,
                  input ready);
  modport sink (input valid, read_data, irq_request, data_pending, motion_held,
                output ready);
endinterface

interface smup_cfg_if;
  logic valid;
  logic ready;
  logic irq_enable;

  modport source (output valid, irq_enable, input ready);
  modport sink (input valid, irq_enable, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/serial_mouse_uart_port.sv @@
// Serial mouse port in the style of an 8250 UART. Mouse events and host port reads and
// writes enter as words on in_i; each produces exactly one result word on out_o, in order.
// One word is accepted every cycle while results are taken; a word passes an input register
// and one pass of logic against the register-array receive FIFO, and its result is written
// to the output register when it leaves the input register, held there until taken. A mouse
// event pushes its whole five-byte packet in that single pass, or folds its motion into the
// saturating hold registers when the FIFO has no room for a packet. No clearing pass follows
// reset. irq_enable on cfg_i may be written at any time; the port is always ready.

`default_nettype none

`include "assert_macros.svh"

module serial_mouse_uart_port import smup_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  smup_cfg_if.sink    cfg_i,
  smup_in_if.sink     in_i,
  smup_out_if.source  out_o
);

  logic              irq_en_q;
  logic              s1_valid_q;
  item_t             s1_q;
  logic              out_valid_q;
  result_t           res_q, res_d;
  logic              adv;
  logic              in_ready;

  logic signed [7:0] held_dx_q, held_dx_d;
  logic signed [7:0] held_dy_q, held_dy_d;
  logic              latch_q, latch_d;
  logic [7:0]        lcr_q, lcr_d;
  logic [7:0]        lsr_q, lsr_d;

  fifo_ctrl_t        ctrl;
  fifo_stat_t        stat;

  logic signed [12:0] sum_x, sum_y;
  logic [7:0]         eff_x, eff_y;
  logic [2:0]         btn_map;
  logic               is_read;
  logic               is_port;

  assign adv      = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !s1_valid_q || adv;
  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  assign is_read = (s1_q.kind == KIND_READ);
  assign is_port = (s1_q.kind == KIND_READ) || (s1_q.kind == KIND_WRITE);

  assign sum_x   = 13'($signed(s1_q.delta_x)) + 13'(held_dx_q);
  assign sum_y   = 13'($signed(s1_q.delta_y)) + 13'(held_dy_q);
  // left goes to bit 2, middle to bit 1, right to bit 0
  assign btn_map = {s1_q.buttons[0], s1_q.buttons[2], s1_q.buttons[1]};

  always_comb begin
    res_d     = '0;
    ctrl      = '0;
    held_dx_d = held_dx_q;
    held_dy_d = held_dy_q;
    latch_d   = latch_q;
    lcr_d     = lcr_q;
    lsr_d     = lsr_q;
    eff_x     = s1_q.delta_x[7:0];
    eff_y     = s1_q.delta_y[7:0];

    case (kind_e'(s1_q.kind))
      KIND_MOUSE: begin
        if (!stat.pkt_room) begin
          held_dx_d         = clamp_motion(sum_x);
          held_dy_d         = clamp_motion(sum_y);
          res_d.motion_held = 1'b1;
        end else begin
          // motion is clamped only when something was held back
          if (held_dx_q != '0 || held_dy_q != '0) begin
            eff_x = clamp_motion(sum_x);
            eff_y = clamp_motion(sum_y);
          end
          held_dx_d         = '0;
          held_dy_d         = '0;
          ctrl.push_pkt     = 1'b1;
          ctrl.pkt[0]       = PKT_SYNC | {5'd0, btn_map};
          ctrl.pkt[1]       = 8'd0 - eff_x;
          ctrl.pkt[2]       = 8'd0 - eff_y;
          ctrl.pkt[3]       = 8'd0;
          ctrl.pkt[4]       = 8'd0;
          res_d.irq_request = irq_en_q;
        end
      end
      KIND_READ, KIND_WRITE: begin
        case (reg_off_e'(s1_q.port_offset))
          REG_DATA: begin
            if (latch_q) begin
              res_d.read_data = DLL_VALUE;
            end else if (is_read) begin
              ctrl.pop        = 1'b1;
              res_d.read_data = stat.empty ? 8'd0 : stat.head;
              lsr_d           = LSR_IDLE;
            end else begin
              if (s1_q.write_data == ECHO_TRIGGER) begin
                ctrl.pop      = 1'b1;
                ctrl.push_one = 1'b1;
                ctrl.one_byte = ECHO_BYTE;
              end
              lsr_d = LSR_IDLE;
            end
          end
          REG_IER: latch_d = 1'b0;
          REG_LCR: begin
            if (is_read) begin
              res_d.read_data = lcr_q;
            end else begin
              lcr_d   = s1_q.write_data;
              latch_d = s1_q.write_data[7];
              lsr_d   = LSR_IDLE;
            end
          end
          REG_MCR: res_d.read_data = MCR_VALUE;
          REG_LSR: begin
            res_d.read_data = lsr_q;
            lsr_d           = LSR_AFTER_RD;
          end
          REG_MSR: res_d.read_data = MSR_VALUE;
          default: ;
        endcase
      end
      default: ;
    endcase

    // bytes waiting after this word
    if (ctrl.push_pkt || ctrl.push_one) begin
      res_d.data_pending = 1'b1;
    end else if (ctrl.pop) begin
      res_d.data_pending = !(stat.empty || stat.single);
    end else begin
      res_d.data_pending = !stat.empty;
    end

    if (!adv) ctrl = '0;
  end

  smup_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_en_q    <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      held_dx_q   <= '0;
      held_dy_q   <= '0;
      latch_q     <= 1'b0;
      lcr_q       <= LCR_RESET;
      lsr_q       <= LSR_IDLE;
    end else begin
      if (cfg_i.valid) irq_en_q <= cfg_i.irq_enable;
      if (in_ready) s1_valid_q <= in_i.valid;
      if (adv) begin
        out_valid_q <= 1'b1;
        held_dx_q   <= held_dx_d;
        held_dy_q   <= held_dy_d;
        latch_q     <= latch_d;
        lcr_q       <= lcr_d;
        lsr_q       <= lsr_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s1_q.kind        <= in_i.kind;
      s1_q.buttons     <= in_i.buttons;
      s1_q.delta_x     <= in_i.delta_x;
      s1_q.delta_y     <= in_i.delta_y;
      s1_q.port_offset <= in_i.port_offset;
      s1_q.write_data  <= in_i.write_data;
    end
    if (adv) res_q <= res_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.read_data    = res_q.read_data;
  assign out_o.irq_request  = res_q.irq_request;
  assign out_o.data_pending = res_q.data_pending;
  assign out_o.motion_held  = res_q.motion_held;

  `SMUP_ASSERT_ALWAYS(held_in_range, held_dx_q >= HELD_MIN && held_dy_q >= HELD_MIN,
    "held motion outside clamp range")
  `SMUP_ASSERT_ALWAYS(irq_not_with_hold,
    !(out_valid_q && res_q.irq_request && res_q.motion_held), "interrupt raised for held motion")
  `SMUP_ASSERT_NEXT(ier_clears_latch, adv && is_port && s1_q.port_offset == REG_IER,
    !latch_q, "divisor latch not cleared")

endmodule

`default_nettype wire

@@ hw/rtl/smup_fifo.sv @@
`default_nettype none

`include "assert_macros.svh"

module smup_fifo import smup_pkg::*; #(
  parameter int unsigned DEPTH = 5
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  fifo_ctrl_t ctrl_i,
  output fifo_stat_t stat_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW:0]   DepthW    = (PW + 1)'(DEPTH);
  localparam logic [CW-1:0] CntDepth  = CW'(DEPTH);
  localparam logic [CW-1:0] RoomLimit = CW'(DEPTH - PACKET_BYTES);
  localparam logic [CW-1:0] PktCount  = CW'(PACKET_BYTES);

  logic [7:0]    mem_q [DEPTH];
  logic [PW-1:0] rp_q, rp_d;
  logic [PW-1:0] wp_q, wp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] cnt_mid;
  logic          pop_eff;
  logic          push_one_eff;
  logic [PACKET_BYTES-1:0][PW-1:0] slot;

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p, input logic [PW:0] k);
    logic [PW:0] s;
    s = {1'b0, p} + k;
    if (s >= DepthW) s = s - DepthW;
    return s[PW-1:0];
  endfunction

  always_comb begin
    for (int k = 0; k < PACKET_BYTES; k++) begin
      slot[k] = wrap_add(wp_q, (PW + 1)'(k));
    end
  end

  always_comb begin
    pop_eff      = ctrl_i.pop && (cnt_q != '0);
    cnt_mid      = cnt_q - CW'(pop_eff);
    // after a pop there is always space for a single byte
    push_one_eff = ctrl_i.push_one && (cnt_mid != CntDepth);
    cnt_d        = cnt_mid + CW'(push_one_eff);
    wp_d         = wp_q;
    if (ctrl_i.push_pkt) begin
      cnt_d = cnt_mid + PktCount;
      wp_d  = wrap_add(wp_q, (PW + 1)'(PACKET_BYTES));
    end else if (push_one_eff) begin
      wp_d = wrap_add(wp_q, (PW + 1)'(1));
    end
    rp_d = pop_eff ? wrap_add(rp_q, (PW + 1)'(1)) : rp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q  <= '0;
      wp_q  <= '0;
      cnt_q <= '0;
    end else begin
      rp_q  <= rp_d;
      wp_q  <= wp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push_pkt) begin
      for (int k = 0; k < PACKET_BYTES; k++) begin
        mem_q[slot[k]] <= ctrl_i.pkt[k];
      end
    end else if (push_one_eff) begin
      mem_q[wp_q] <= ctrl_i.one_byte;
    end
  end

  assign stat_o.empty    = (cnt_q == '0);
  assign stat_o.single   = (cnt_q == CW'(1));
  assign stat_o.pkt_room = (cnt_q <= RoomLimit);
  assign stat_o.head     = mem_q[rp_q];

  `SMUP_ASSERT_ALWAYS(cnt_in_range, cnt_q <= CntDepth, "fifo count above depth")
  `SMUP_ASSERT_IMPL(pkt_needs_room, ctrl_i.push_pkt, cnt_q <= RoomLimit,
    "packet push without room")
  `SMUP_ASSERT_IMPL(ptrs_meet, cnt_q == '0 || cnt_q == CntDepth, rp_q == wp_q,
    "pointers disagree with count")

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int FIFO_SLOTS = 5;
  localparam int PKT_LEN = 5;
  localparam int HOLD_HI = 127;
  localparam int HOLD_LO = -126;
  localparam int GAP_MAX = 13;
  localparam int RANDOM_WORDS = 1650;
  localparam int PHASES = 8;
  localparam int TAIL_CYCLES = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX = 10;
  localparam logic [1:0] KIND_NONE = 2'd3;

  logic clk_i;
  logic rst_ni;

  smup_cfg_if cfg_if ();
  smup_in_if  in_if ();
  smup_out_if out_if ();

  serial_mouse_uart_port #(.FIFO_DEPTH(FIFO_SLOTS)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // port state as the host sees it
  logic [7:0] rx_bytes [FIFO_SLOTS];
  int         rd_ptr;
  int         wr_ptr;
  bit         rx_empty;
  bit         rx_full;
  int         acc_dx;
  int         acc_dy;
  bit         divisor_latch;
  logic [7:0] lcr;
  logic [7:0] lsr;
  bit         data_ready;
  bit         irq_en;

  smup_pkg::result_t due_replies[$];
  int  fail_count = 0;
  int  report_count = 0;
  int  sent_count = 0;
  int  cycle_count = 0;
  bit  sender_burst = 0;
  bit  receiver_burst = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic void reset_port_state();
    foreach (rx_bytes[i]) rx_bytes[i] = 8'h00;
    rd_ptr = 0;
    wr_ptr = 0;
    rx_empty = 1;
    rx_full = 0;
    acc_dx = 0;
    acc_dy = 0;
    divisor_latch = 0;
    lcr = smup_pkg::LCR_RESET;
    lsr = smup_pkg::LSR_IDLE;
    data_ready = 0;
    irq_en = 0;
  endfunction

  function automatic int limit_motion(int v);
    if (v > HOLD_HI) return HOLD_HI;
    if (v < HOLD_LO) return HOLD_LO;
    return v;
  endfunction

  function automatic void rx_push(logic [7:0] b);
    if (rx_full) return;
    rx_bytes[wr_ptr] = b;
    rx_empty = 0;
    wr_ptr = (wr_ptr + 1) % FIFO_SLOTS;
    if (wr_ptr == rd_ptr) rx_full = 1;
    data_ready = 1;
  endfunction

  function automatic logic [7:0] rx_pop();
    logic [7:0] b;
    if (rx_empty) begin
      data_ready = 0;
      return 8'h00;
    end
    b = rx_bytes[rd_ptr];
    rd_ptr = (rd_ptr + 1) % FIFO_SLOTS;
    if (rd_ptr == wr_ptr) begin
      data_ready = 0;
      rx_empty = 1;
    end
    rx_full = 0;
    return b;
  endfunction

  function automatic bit packet_blocked();
    int room;
    if (rx_empty) return 0;
    if (rx_full) return 1;
    if (rd_ptr > wr_ptr) room = rd_ptr - wr_ptr;
    else room = FIFO_SLOTS - (wr_ptr - rd_ptr);
    return room < PKT_LEN;
  endfunction

  function automatic smup_pkg::result_t predict_reply(smup_pkg::item_t w);
    smup_pkg::result_t r;
    int dx;
    int dy;
    logic [2:0] btn;
    bit is_read;
    r = '0;
    dx = $signed(w.delta_x);
    dy = $signed(w.delta_y);
    is_read = (w.kind == smup_pkg::KIND_READ);
    case (w.kind)
      smup_pkg::KIND_MOUSE: begin
        // left -> bit2, right -> bit0, middle -> bit1
        btn = {w.buttons[0], w.buttons[2], w.buttons[1]};
        if (packet_blocked()) begin
          acc_dx = limit_motion(acc_dx + dx);
          acc_dy = limit_motion(acc_dy + dy);
          r.motion_held = 1'b1;
        end else begin
          if (acc_dx != 0 || acc_dy != 0) begin
            dx = limit_motion(dx + acc_dx);
            dy = limit_motion(dy + acc_dy);
          end
          acc_dx = 0;
          acc_dy = 0;
          rx_push(smup_pkg::PKT_SYNC | 8'(btn));
          rx_push(8'(-dx));
          rx_push(8'(-dy));
          rx_push(8'h00);
          rx_push(8'h00);
          r.irq_request = irq_en;
        end
      end
      smup_pkg::KIND_READ, smup_pkg::KIND_WRITE: begin
        case (w.port_offset)
          smup_pkg::REG_DATA: begin
            if (divisor_latch) begin
              r.read_data = smup_pkg::DLL_VALUE;
            end else if (is_read) begin
              r.read_data = rx_pop();
              lsr = smup_pkg::LSR_IDLE;
            end else begin
              if (w.write_data == smup_pkg::ECHO_TRIGGER) begin
                void'(rx_pop());
                rx_push(smup_pkg::ECHO_BYTE);
              end
              lsr = smup_pkg::LSR_IDLE;
            end
          end
          smup_pkg::REG_IER: divisor_latch = 0;
          smup_pkg::REG_LCR: begin
            if (is_read) begin
              r.read_data = lcr;
            end else begin
              lcr = w.write_data;
              divisor_latch = w.write_data[7];
              lsr = smup_pkg::LSR_IDLE;
            end
          end
          smup_pkg::REG_MCR: r.read_data = smup_pkg::MCR_VALUE;
          smup_pkg::REG_LSR: begin
            r.read_data = lsr;
            lsr = smup_pkg::LSR_AFTER_RD;
          end
          smup_pkg::REG_MSR: r.read_data = smup_pkg::MSR_VALUE;
          default: ;
        endcase
      end
      default: ;
    endcase
    r.data_pending = data_ready;
    return r;
  endfunction

  task automatic report_failure(string what, smup_pkg::result_t want, smup_pkg::result_t got);
    fail_count++;
    if (report_count < REPORT_MAX) begin
      report_count++;
      $display("%0t %s: exp rd=%h irq=%b pend=%b held=%b, got rd=%h irq=%b pend=%b held=%b",
               $realtime, what, want.read_data, want.irq_request, want.data_pending,
               want.motion_held, got.read_data, got.irq_request, got.data_pending,
               got.motion_held);
    end
  endtask

  always @(posedge clk_i) begin : check_replies
    smup_pkg::result_t got;
    smup_pkg::result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.read_data    = out_if.read_data;
      got.irq_request  = out_if.irq_request;
      got.data_pending = out_if.data_pending;
      got.motion_held  = out_if.motion_held;
      if (due_replies.size() == 0) begin
        report_failure("unexpected word", '0, got);
      end else begin
        want = due_replies.pop_front();
        if (got.read_data !== want.read_data || got.irq_request !== want.irq_request ||
            got.data_pending !== want.data_pending || got.motion_held !== want.motion_held)
          report_failure("mismatch", want, got);
      end
    end
  end

  // result side: random stalls, with stretches of none
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = receiver_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      if ($urandom_range(0, 39) == 0) receiver_burst = ~receiver_burst;
    end
  end

  task automatic send_word(input smup_pkg::item_t w);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.kind        <= w.kind;
    in_if.buttons     <= w.buttons;
    in_if.delta_x     <= w.delta_x;
    in_if.delta_y     <= w.delta_y;
    in_if.port_offset <= w.port_offset;
    in_if.write_data  <= w.write_data;
    do @(posedge clk_i); while (!in_if.ready);
    due_replies.push_back(predict_reply(w));
    sent_count++;
    if ($urandom_range(0, 39) == 0) sender_burst = ~sender_burst;
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_irq_enable(input bit en);
    wait_idle();
    cfg_if.valid      <= 1'b1;
    cfg_if.irq_enable <= en;
    do @(posedge clk_i); while (!cfg_if.ready);
    irq_en = en;
    cfg_if.valid <= 1'b0;
  endtask

  function automatic smup_pkg::item_t random_word();
    smup_pkg::item_t w;
    w.kind        = 2'($urandom_range(0, 3));
    w.buttons     = 3'($urandom_range(0, 7));
    w.delta_x     = 12'($urandom_range(0, 4095));
    w.delta_y     = 12'($urandom_range(0, 4095));
    w.port_offset = 3'($urandom_range(0, 7));
    w.write_data  = 8'($urandom_range(0, 255));
    return w;
  endfunction

  function automatic logic signed [11:0] pick_delta();
    case ($urandom_range(0, 9))
      0: return -12'sd2048;
      1: return 12'sd2047;
      2, 3: return 12'($urandom_range(0, 4095));
      default: return 12'($urandom_range(0, 60) - 30);
    endcase
  endfunction

  function automatic smup_pkg::item_t mouse_word(logic [2:0] btn, logic signed [11:0] dx,
                                                 logic signed [11:0] dy);
    smup_pkg::item_t w;
    w = random_word();
    w.kind    = smup_pkg::KIND_MOUSE;
    w.buttons = btn;
    w.delta_x = dx;
    w.delta_y = dy;
    return w;
  endfunction

  function automatic smup_pkg::item_t port_word(logic [1:0] kind, smup_pkg::reg_off_e off,
                                                logic [7:0] data);
    smup_pkg::item_t w;
    w = random_word();
    w.kind        = kind;
    w.port_offset = off;
    w.write_data  = data;
    return w;
  endfunction

  task automatic test_port_registers();
    write_irq_enable(1'b0);
    send_word(port_word(smup_pkg::KIND_READ, smup_pkg::REG_LCR, 8'h00));
    send_word(port_word(smup_pkg::KIND_READ, smup_pkg::REG_LSR, 8'h00));
    // line status reads once, then falls back
    send_word(port_word(smup_pkg::KIND_READ, smup_pkg::REG_LSR, 8'h00));
    send_word(port_word(smup_pkg::KIND_READ, smup_pkg::REG_MCR, 8'h00));
    send_word(port_word(smup_pkg::KIND_WRITE, smup_pkg::REG_MSR, 8'hff));
    send_word(port_word(smup_pkg::KIND_READ, smup_pkg::REG_IIR, 8'h00));
    send_word(port_word(smup_pkg::KIND_WRITE, smup_pkg::REG_SCR, 8'haa));
    send_word(port_word(smup_pkg::KIND_READ, smup_pkg::REG_DATA, 8'h00));
    send_word(port_word(KIND_NONE, smup_pkg::REG_DATA, 8'h00));
    send_word(port_word(smup_pkg::KIND_WRITE, smup_pkg::REG_LCR, 8'h80));
    send_word(port_word(smup_pkg::KIND_READ, smup_pkg::REG_DATA, 8'h00));
    send_word(port_word(smup_pkg::KIND_WRITE, smup_pkg::REG_DATA, smup_pkg::ECHO_TRIGGER));
    send_word(port_word(smup_pkg::KIND_WRITE, smup_pkg::REG_IER, 8'h00));
    send_word(port_word(smup_pkg::KIND_READ, smup_pkg::REG_LCR, 8'h00));
    send_word(port_word(smup_pkg::KIND_WRITE, smup_pkg::REG_LCR, 8'h03));
  endtask

  task automatic test_mouse_packets();
    write_irq_enable(1'b1);
    send_word(mouse_word(3'd7, 12'sd2047, -12'sd2048));
    // fifo busy: motion folds into the clamped accumulators
    send_word(mouse_word(3'd1, 12'sd2047, 12'sd2047));
    send_word(mouse_word(3'd2, -12'sd2048, 12'sd5));
    // echo on a full fifo drops the oldest byte first
    send_word(port_word(smup_pkg::KIND_WRITE, smup_pkg::REG_DATA, smup_pkg::ECHO_TRIGGER));
    repeat (PKT_LEN) send_word(port_word(smup_pkg::KIND_READ, smup_pkg::REG_DATA, 8'h00));
    send_word(mouse_word(3'd4, 12'sd0, 12'sd0));
  endtask

  task automatic test_random_traffic();
    int phase_end;
    int extra;
    for (int ph = 0; ph < PHASES; ph++) begin
      // idle before each setting change, so all outstanding replies drain first
      if (ph < 2) write_irq_enable(ph[0]);
      else write_irq_enable(1'($urandom_range(0, 1)));
      phase_end = sent_count + RANDOM_WORDS / PHASES;
      while (sent_count < phase_end) begin
        if ($urandom_range(0, 99) < 15) begin
          send_word(random_word());
        end else begin
          if ($urandom_range(0, 3) == 0)
            send_word(port_word(smup_pkg::KIND_WRITE, smup_pkg::REG_LCR,
                                8'($urandom_range(0, 127))));
          send_word(mouse_word(3'($urandom_range(0, 7)), pick_delta(), pick_delta()));
          if ($urandom_range(0, 9) < 3) begin
            extra = $urandom_range(1, 3);
            repeat (extra)
              send_word(mouse_word(3'($urandom_range(0, 7)), pick_delta(), pick_delta()));
          end
          if ($urandom_range(0, 3) == 0)
            send_word(port_word(smup_pkg::KIND_READ, smup_pkg::REG_LSR, 8'h00));
          if ($urandom_range(0, 9) == 0)
            send_word(port_word(smup_pkg::KIND_WRITE, smup_pkg::REG_DATA,
                                smup_pkg::ECHO_TRIGGER));
          // partial reads leave bytes behind so later events get held
          extra = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 6) : PKT_LEN;
          repeat (extra) send_word(port_word(smup_pkg::KIND_READ, smup_pkg::REG_DATA, 8'h00));
        end
      end
    end
  endtask

  initial begin
    in_if.valid       <= 1'b0;
    in_if.kind        <= '0;
    in_if.buttons     <= '0;
    in_if.delta_x     <= '0;
    in_if.delta_y     <= '0;
    in_if.port_offset <= '0;
    in_if.write_data  <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.irq_enable <= 1'b0;
    rst_ni            <= 1'b0;
    reset_port_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_port_registers();
    test_mouse_packets();
    test_random_traffic();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
